// ===== rtl/core/urm_pkg.sv =====
// Package for the UART register model: request codes, register offsets,
// register bit masks and the transfer payload structs. No dependencies.

package urm_pkg;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_HOST_RX = 2'd2,
    REQ_TX_TICK = 2'd3
  } req_type_e;

  localparam logic [2:0] REG_RBR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR     = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  localparam logic [7:0] IER_RDA       = 8'h01;
  localparam logic [7:0] IER_TX_EMPTY  = 8'h02;
  localparam logic [7:0] IIR_NO_INT    = 8'h01;
  localparam logic [7:0] IIR_TX_EMPTY  = 8'h02;
  localparam logic [7:0] IIR_RDA       = 8'h04;
  localparam logic [7:0] LCR_DIV_LATCH = 8'h80;
  localparam logic [7:0] LSR_DR        = 8'h01;
  localparam logic [7:0] LSR_TX_EMPTY  = 8'h20;
  localparam logic [7:0] LSR_TX_IDLE   = 8'h40;
  localparam logic [7:0] LSR_RESET     = LSR_TX_EMPTY | LSR_TX_IDLE;

  typedef struct packed {
    req_type_e  req_type;
    logic [2:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] host_rx_byte;
  } urm_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raise;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       event_refused;
  } urm_rsp_t;

endpackage

// ===== rtl/core/urm_regbank.sv =====
// Register bank of the UART register model and the update logic for one request.
// Depends on urm_pkg.

module urm_regbank
  import urm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  urm_req_t req_i,
  output urm_rsp_t rsp_o
);

  logic [7:0] rbr_q, rbr_d;
  logic [7:0] thr_q, thr_d;
  logic [7:0] ier_q, ier_d;
  logic [7:0] iir_q, iir_d;
  logic [7:0] lcr_q, lcr_d;
  logic [7:0] mcr_q, mcr_d;
  logic [7:0] lsr_q, lsr_d;
  logic [7:0] scr_q, scr_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic       ack_q, ack_d;
  logic       dlab;

  assign dlab = (lcr_q & LCR_DIV_LATCH) != 8'h00;

  always_comb begin
    rbr_d = rbr_q;
    thr_d = thr_q;
    ier_d = ier_q;
    iir_d = iir_q;
    lcr_d = lcr_q;
    mcr_d = mcr_q;
    lsr_d = lsr_q;
    scr_d = scr_q;
    dll_d = dll_q;
    dlm_d = dlm_q;
    ack_d = ack_q;
    rsp_o = '0;
    unique case (req_i.req_type)
      REQ_READ: begin
        unique case (req_i.reg_address)
          REG_RBR_THR: begin
            if (dlab) begin
              rsp_o.read_data = dll_q;
            end else begin
              rsp_o.read_data = rbr_q;
              rbr_d = 8'h00;
              iir_d = IIR_NO_INT;
              lsr_d = lsr_q & ~LSR_DR;
            end
          end
          REG_IER: rsp_o.read_data = dlab ? dlm_q : ier_q;
          REG_IIR: begin
            rsp_o.read_data = iir_q;
            if (iir_q == IIR_TX_EMPTY) begin
              iir_d = IIR_NO_INT;
            end
          end
          REG_LCR: rsp_o.read_data = lcr_q;
          REG_MCR: rsp_o.read_data = mcr_q;
          REG_LSR: rsp_o.read_data = lsr_q;
          REG_MSR: rsp_o.read_data = 8'h00;
          default: rsp_o.read_data = scr_q;
        endcase
      end
      REQ_WRITE: begin
        unique case (req_i.reg_address)
          REG_RBR_THR: begin
            if (dlab) begin
              dll_d = req_i.write_data;
            end else begin
              thr_d = req_i.write_data;
              iir_d = IIR_NO_INT;
              lsr_d = lsr_q & ~LSR_TX_EMPTY;
            end
          end
          REG_IER: begin
            if (dlab) begin
              dlm_d = req_i.write_data;
            end else begin
              ier_d = req_i.write_data;
            end
          end
          REG_LCR: lcr_d = req_i.write_data;
          REG_MCR: mcr_d = req_i.write_data;
          REG_SCR: scr_d = req_i.write_data;
          default: ;
        endcase
      end
      default: begin
        if (ack_q && (iir_q != IIR_NO_INT)) begin
          rsp_o.event_refused = 1'b1;
        end else begin
          if (req_i.req_type == REQ_HOST_RX) begin
            if ((ier_q & IER_RDA) != 8'h00) begin
              rbr_d = req_i.host_rx_byte;
              lsr_d = lsr_q | LSR_DR;
              iir_d = IIR_RDA;
              rsp_o.irq_raise = 1'b1;
            end
          end else if ((lsr_q & LSR_TX_EMPTY) == 8'h00) begin
            rsp_o.tx_byte  = thr_q;
            rsp_o.tx_valid = 1'b1;
            thr_d = 8'h00;
            lsr_d = lsr_q | LSR_TX_EMPTY;
            if ((ier_q & IER_TX_EMPTY) != 8'h00) begin
              iir_d = IIR_TX_EMPTY;
              rsp_o.irq_raise = 1'b1;
            end
          end
          ack_d = rsp_o.irq_raise;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbr_q <= 8'h00;
      thr_q <= 8'h00;
      ier_q <= 8'h00;
      iir_q <= IIR_NO_INT;
      lcr_q <= 8'h00;
      mcr_q <= 8'h00;
      lsr_q <= LSR_RESET;
      scr_q <= 8'h00;
      dll_q <= 8'h00;
      dlm_q <= 8'h00;
      ack_q <= 1'b0;
    end else if (fire_i) begin
      rbr_q <= rbr_d;
      thr_q <= thr_d;
      ier_q <= ier_d;
      iir_q <= iir_d;
      lcr_q <= lcr_d;
      mcr_q <= mcr_d;
      lsr_q <= lsr_d;
      scr_q <= scr_d;
      dll_q <= dll_d;
      dlm_q <= dlm_d;
      ack_q <= ack_d;
    end
  end

  a_irq_sets_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rsp_o.irq_raise |=> ack_q && (iir_q != IIR_NO_INT))
    else $error("raised interrupt did not arm acknowledgment");

  a_tx_sets_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rsp_o.tx_valid |=> (lsr_q & LSR_TX_EMPTY) != 8'h00)
    else $error("transmit did not set the transmit-empty bit");

  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rsp_o.event_refused |=> $stable(iir_q) && $stable(lsr_q) && ack_q)
    else $error("refused event changed state");

  a_bus_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((req_i.req_type == REQ_READ) || (req_i.req_type == REQ_WRITE)) |->
      !rsp_o.irq_raise && !rsp_o.tx_valid && !rsp_o.event_refused)
    else $error("bus access produced a host event result");

endmodule

// ===== rtl/core/uart_register_model.sv =====
// Top level of the UART register model: input register, register bank and
// result register. Depends on urm_pkg and urm_regbank.
//
//   channel | payload   | valid       | stall
//   input   | in_data_i | in_valid_i  | in_stall_o
//   output  | out_data_o| out_valid_o | out_stall_i
//
// A request is held in the input register and is applied to the register
// bank as it moves into the result register. One request is taken per cycle
// when the output is not stalled. Reset clears the bank to its reset
// defaults and empties both registers. An output stall on a waiting result
// holds the result register; when the input register is full it holds that
// register too and raises in_stall_o in the same cycle.

module uart_register_model
  import urm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  urm_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output urm_rsp_t out_data_o
);

  logic     in_valid_q;
  urm_req_t in_data_q;
  logic     out_valid_q;
  urm_rsp_t out_data_q;
  urm_rsp_t rsp;
  logic     out_ready;
  logic     fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  urm_regbank u_regbank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_data_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for uart_register_model: directed and random bus accesses and host
// events against a register-bank predictor, with random idling on both channels.
// Depends on urm_pkg and the uart_register_model RTL.
`timescale 1ns / 1ps

module tb_top
  import urm_pkg::*;
;

  localparam int RANDOM_REQS = 400;

  class uart_bank_tracker;
    logic [7:0] rbr, thr, ier, iir, lcr, mcr, lsr, scr, dll, dlm;
    bit         awaiting_ack;
    urm_rsp_t   pending_rsp[$];
    int         mismatches;

    function new();
      rbr = '0; thr = '0; ier = '0; lcr = '0; mcr = '0; scr = '0; dll = '0; dlm = '0;
      iir = IIR_NO_INT;
      lsr = LSR_RESET;
      awaiting_ack = 1'b0;
      mismatches = 0;
    endfunction

    function urm_rsp_t apply_request(urm_req_t req);
      urm_rsp_t rsp;
      logic     dlab;
      rsp = '0;
      dlab = (lcr & LCR_DIV_LATCH) != 8'h00;
      case (req.req_type)
        REQ_READ: begin
          case (req.reg_address)
            REG_RBR_THR: begin
              if (dlab) begin
                rsp.read_data = dll;
              end else begin
                rsp.read_data = rbr;
                rbr = '0;
                iir = IIR_NO_INT;
                lsr = lsr & ~LSR_DR;
              end
            end
            REG_IER: rsp.read_data = dlab ? dlm : ier;
            REG_IIR: begin
              rsp.read_data = iir;
              if (iir == IIR_TX_EMPTY) iir = IIR_NO_INT;
            end
            REG_LCR: rsp.read_data = lcr;
            REG_MCR: rsp.read_data = mcr;
            REG_LSR: rsp.read_data = lsr;
            REG_MSR: rsp.read_data = '0;
            default: rsp.read_data = scr;
          endcase
        end
        REQ_WRITE: begin
          case (req.reg_address)
            REG_RBR_THR: begin
              if (dlab) begin
                dll = req.write_data;
              end else begin
                thr = req.write_data;
                iir = IIR_NO_INT;
                lsr = lsr & ~LSR_TX_EMPTY;
              end
            end
            REG_IER: begin
              if (dlab) dlm = req.write_data;
              else ier = req.write_data;
            end
            REG_LCR: lcr = req.write_data;
            REG_MCR: mcr = req.write_data;
            REG_SCR: scr = req.write_data;
            default: ;
          endcase
        end
        default: begin
          if (awaiting_ack && iir != IIR_NO_INT) begin
            rsp.event_refused = 1'b1;
          end else begin
            awaiting_ack = 1'b0;
            if (req.req_type == REQ_HOST_RX) begin
              if ((ier & IER_RDA) != 8'h00) begin
                rbr = req.host_rx_byte;
                lsr = lsr | LSR_DR;
                iir = IIR_RDA;
                rsp.irq_raise = 1'b1;
              end
            end else if ((lsr & LSR_TX_EMPTY) == 8'h00) begin
              rsp.tx_byte = thr;
              rsp.tx_valid = 1'b1;
              thr = '0;
              lsr = lsr | LSR_TX_EMPTY;
              if ((ier & IER_TX_EMPTY) != 8'h00) begin
                iir = IIR_TX_EMPTY;
                rsp.irq_raise = 1'b1;
              end
            end
            if (rsp.irq_raise) awaiting_ack = 1'b1;
          end
        end
      endcase
      return rsp;
    endfunction

    function void note_request(urm_req_t req);
      pending_rsp.push_back(apply_request(req));
    endfunction

    function void flag(string what, urm_rsp_t exp, urm_rsp_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: exp rd=%h irq=%b txv=%b txb=%h ref=%b,",
                 $realtime, what, exp.read_data, exp.irq_raise, exp.tx_valid, exp.tx_byte,
                 exp.event_refused);
        $display("  got rd=%h irq=%b txv=%b txb=%h ref=%b",
                 got.read_data, got.irq_raise, got.tx_valid, got.tx_byte,
                 got.event_refused);
      end
    endfunction

    function void check_response(urm_rsp_t got);
      urm_rsp_t exp;
      if (pending_rsp.size() == 0) begin
        flag("unexpected transfer", '0, got);
      end else begin
        exp = pending_rsp.pop_front();
        if (got.read_data !== exp.read_data || got.irq_raise !== exp.irq_raise ||
            got.tx_valid !== exp.tx_valid || got.tx_byte !== exp.tx_byte ||
            got.event_refused !== exp.event_refused) begin
          flag("mismatch", exp, got);
        end
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  urm_req_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  urm_rsp_t out_data_o;

  uart_bank_tracker bank_sb;
  int in_calm = 0;
  int out_calm = 0;

  uart_register_model i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic urm_req_t compose_req(req_type_e t, logic [2:0] a, logic [7:0] wd,
                                           logic [7:0] rx);
    urm_req_t req;
    req.req_type = t;
    req.reg_address = a;
    req.write_data = wd;
    req.host_rx_byte = rx;
    return req;
  endfunction

  task automatic send_request(urm_req_t req);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    bank_sb.note_request(req);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) bank_sb.check_response(out_data_o);
  end

  initial begin
    int n;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      n = draw_wait(out_calm);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    urm_req_t req;
    int       w;
    bank_sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(compose_req(REQ_READ, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_READ, REG_IIR, 8'h00, 8'h00));
    send_request(compose_req(REQ_READ, REG_LSR, 8'h00, 8'h00));
    send_request(compose_req(REQ_READ, REG_MSR, 8'h00, 8'h00));
    send_request(compose_req(REQ_HOST_RX, REG_RBR_THR, 8'h00, 8'hFF));
    send_request(compose_req(REQ_TX_TICK, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_LCR, 8'h80, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_RBR_THR, 8'hFF, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_IER, 8'hFF, 8'h00));
    send_request(compose_req(REQ_READ, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_READ, REG_IER, 8'h00, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_LCR, 8'h03, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_IER, 8'h03, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_IIR, 8'hFF, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_LSR, 8'h00, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_MSR, 8'hFF, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_SCR, 8'hFF, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_MCR, 8'h1F, 8'h00));
    send_request(compose_req(REQ_HOST_RX, REG_RBR_THR, 8'h00, 8'h5A));
    send_request(compose_req(REQ_HOST_RX, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_READ, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_WRITE, REG_RBR_THR, 8'hA5, 8'h00));
    send_request(compose_req(REQ_TX_TICK, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_TX_TICK, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_READ, REG_IIR, 8'h00, 8'h00));
    send_request(compose_req(REQ_TX_TICK, REG_RBR_THR, 8'h00, 8'h00));
    send_request(compose_req(REQ_READ, REG_SCR, 8'h00, 8'h00));

    repeat (RANDOM_REQS) begin
      req.reg_address = 3'($urandom_range(0, 7));
      req.write_data = 8'($urandom_range(0, 255));
      req.host_rx_byte = 8'($urandom_range(0, 255));
      w = $urandom_range(0, 99);
      if (w < 25) begin
        req.req_type = REQ_READ;
        if ($urandom_range(0, 1) == 0) begin
          req.reg_address = ($urandom_range(0, 1) == 0) ? REG_IIR : REG_RBR_THR;
        end
      end else if (w < 50) begin
        req.req_type = REQ_WRITE;
        if (req.reg_address == REG_LCR) req.write_data[7] = ($urandom_range(0, 3) == 0);
      end else if (w < 75) begin
        req.req_type = REQ_HOST_RX;
      end else begin
        req.req_type = REQ_TX_TICK;
      end
      send_request(req);
    end
    in_valid_i <= 1'b0;

    while (bank_sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bank_sb.pending_rsp.size() != 0) begin
      bank_sb.flag("missing transfer", bank_sb.pending_rsp[0], '0);
    end
    if (bank_sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
